/* rtl/core/rti_pkg.sv */
// ----------------------------------------------------------------------------
// Ray-triangle intersection package
// Shared codes, register indices and control types for the intersection core.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int MAXD_BITS = 31;
	// Cross stages, dot stages, one divider stage per distance bit, output register.
	localparam int LATENCY = 3 + 5 + MAXD_BITS + 1;

	typedef enum logic [2:0] {
		REASON_HIT,
		REASON_PARALLEL,
		REASON_U_OUT,
		REASON_V_OUT,
		REASON_T_OUT
	} reason_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z,
		REG_MAX_DIST
	} reg_idx_t;

	typedef struct packed {
		logic    valid;
		reason_t reason;
	} ctl_t;

endpackage

/* rtl/core/rti_cross.sv */
// ----------------------------------------------------------------------------
// Edge and cross-product stages
// Forms the triangle edges and origin offset, then d x e2 and s x e1.
// ----------------------------------------------------------------------------
module rti_cross #(
	parameter int COORD_BITS = 32,
	localparam int EW = COORD_BITS + 1,
	localparam int XW = 2 * EW + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] v0 [3],
	input  logic signed [COORD_BITS-1:0] v1 [3],
	input  logic signed [COORD_BITS-1:0] v2 [3],
	input  logic signed [COORD_BITS-1:0] org [3],
	input  logic signed [COORD_BITS-1:0] dir [3],
	output logic                         valid_o,
	output logic signed [EW-1:0]         e1_o [3],
	output logic signed [EW-1:0]         e2_o [3],
	output logic signed [EW-1:0]         s_o [3],
	output logic signed [XW-1:0]         h_o [3],
	output logic signed [XW-1:0]         q_o [3]
);

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [EW-1:0] dx [3];
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [2*EW-1:0] hp_s2 [6], qp_s2 [6];
	logic signed [XW-1:0] h_s3 [3], q_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dx[i] = EW'(dir[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= EW'(v1[i]) - EW'(v0[i]);
			e2_s1[i] <= EW'(v2[i]) - EW'(v0[i]);
			s_s1[i]  <= EW'(org[i]) - EW'(v0[i]);
			e1_s2[i] <= e1_s1[i];
			e2_s2[i] <= e2_s1[i];
			s_s2[i]  <= s_s1[i];
			e1_s3[i] <= e1_s2[i];
			e2_s3[i] <= e2_s2[i];
			s_s3[i]  <= s_s2[i];
		end
		hp_s2[0] <= dx[1] * e2_s1[2];
		hp_s2[1] <= dx[2] * e2_s1[1];
		hp_s2[2] <= dx[2] * e2_s1[0];
		hp_s2[3] <= dx[0] * e2_s1[2];
		hp_s2[4] <= dx[0] * e2_s1[1];
		hp_s2[5] <= dx[1] * e2_s1[0];
		qp_s2[0] <= s_s1[1] * e1_s1[2];
		qp_s2[1] <= s_s1[2] * e1_s1[1];
		qp_s2[2] <= s_s1[2] * e1_s1[0];
		qp_s2[3] <= s_s1[0] * e1_s1[2];
		qp_s2[4] <= s_s1[0] * e1_s1[1];
		qp_s2[5] <= s_s1[1] * e1_s1[0];
		for (int i = 0; i < 3; i++) begin
			h_s3[i] <= XW'(hp_s2[2*i]) - XW'(hp_s2[2*i+1]);
			q_s3[i] <= XW'(qp_s2[2*i]) - XW'(qp_s2[2*i+1]);
		end
	end

	assign valid_o = vld_s3;
	assign e1_o    = e1_s3;
	assign e2_o    = e2_s3;
	assign s_o     = s_s3;
	assign h_o     = h_s3;
	assign q_o     = q_s3;

endmodule

/* rtl/core/rti_dot.sv */
// ----------------------------------------------------------------------------
// Dot-product and test stages
// Forms det, u, v and t numerators in split partial products, folds the
// sign of det and classifies the triangle.
// ----------------------------------------------------------------------------
module rti_dot #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int EW = COORD_BITS + 1,
	localparam int XW = 2 * EW + 1,
	localparam int PW = 2 * EW + 1,
	localparam int DW = 3 * EW + 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [EW-1:0]         e1 [3],
	input  logic signed [EW-1:0]         e2 [3],
	input  logic signed [EW-1:0]         s [3],
	input  logic signed [XW-1:0]         h [3],
	input  logic signed [XW-1:0]         q [3],
	input  logic signed [COORD_BITS-1:0] dir [3],
	output rti_pkg::ctl_t                ctl_o,
	output logic [DW-1:0]                det_o,
	output logic [DW+FRAC_BITS-1:0]      tsc_o
);

	logic                 vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [EW-1:0] pa [12];
	logic signed [XW-1:0] pb [12];
	logic signed [PW-1:0] pl_s4 [12], ph_s4 [12];
	logic signed [DW-1:0] pr_s5 [12];
	logic signed [DW-1:0] det_s6, un_s6, vn_s6, tn_s6;
	logic signed [DW-1:0] det_s7, un_s7, vn_s7, tn_s7;
	logic                 detz_s7;
	rti_pkg::reason_t     reason;
	rti_pkg::ctl_t        ctl_s8;
	logic [DW-1:0]        det_s8;
	logic [DW+FRAC_BITS-1:0] tsc_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa[i]     = e1[i];
			pb[i]     = h[i];
			pa[3 + i] = s[i];
			pb[3 + i] = h[i];
			pa[6 + i] = EW'(dir[i]);
			pb[6 + i] = q[i];
			pa[9 + i] = e2[i];
			pb[9 + i] = q[i];
		end
	end

	always_comb begin
		if (detz_s7) begin
			reason = rti_pkg::REASON_PARALLEL;
		end else if (un_s7 < 0 || un_s7 > det_s7) begin
			reason = rti_pkg::REASON_U_OUT;
		end else if (vn_s7 < 0 || (DW+1)'(un_s7) + (DW+1)'(vn_s7) > (DW+1)'(det_s7)) begin
			reason = rti_pkg::REASON_V_OUT;
		end else if (tn_s7 <= 0) begin
			reason = rti_pkg::REASON_T_OUT;
		end else begin
			reason = rti_pkg::REASON_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			ctl_s8 <= '0;
		end else begin
			vld_s4        <= in_valid;
			vld_s5        <= vld_s4;
			vld_s6        <= vld_s5;
			vld_s7        <= vld_s6;
			ctl_s8.valid  <= vld_s7;
			ctl_s8.reason <= reason;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 12; k++) begin
			pl_s4[k] <= pa[k] * $signed({1'b0, pb[k][EW-1:0]});
			ph_s4[k] <= pa[k] * $signed(pb[k][XW-1:EW]);
			pr_s5[k] <= (DW'(ph_s4[k]) <<< EW) + DW'(pl_s4[k]);
		end
		det_s6  <= pr_s5[0] + pr_s5[1] + pr_s5[2];
		un_s6   <= pr_s5[3] + pr_s5[4] + pr_s5[5];
		vn_s6   <= pr_s5[6] + pr_s5[7] + pr_s5[8];
		tn_s6   <= pr_s5[9] + pr_s5[10] + pr_s5[11];
		detz_s7 <= (det_s6 == '0);
		det_s7  <= det_s6[DW-1] ? -det_s6 : det_s6;
		un_s7   <= det_s6[DW-1] ? -un_s6 : un_s6;
		vn_s7   <= det_s6[DW-1] ? -vn_s6 : vn_s6;
		tn_s7   <= det_s6[DW-1] ? -tn_s6 : tn_s6;
		det_s8  <= det_s7;
		tsc_s8  <= {tn_s7, {FRAC_BITS{1'b0}}};
	end

	assign ctl_o = ctl_s8;
	assign det_o = det_s8;
	assign tsc_o = tsc_s8;

endmodule

/* rtl/core/rti_div.sv */
// ----------------------------------------------------------------------------
// Distance divider
// Restoring division of the scaled t numerator by det, one quotient bit per
// stage, saturating at the all-ones distance.
// ----------------------------------------------------------------------------
module rti_div #(
	parameter int DW = 102,
	parameter int FRAC_BITS = 16,
	localparam int MD = rti_pkg::MAXD_BITS,
	localparam int RW = DW + FRAC_BITS + MD
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rti_pkg::ctl_t           ctl_i,
	input  logic [DW-1:0]           det_i,
	input  logic [DW+FRAC_BITS-1:0] tsc_i,
	output rti_pkg::ctl_t           ctl_o,
	output logic [MD-1:0]           dist_o
);

	rti_pkg::ctl_t ctl_st [MD];
	logic [RW-1:0] rem_st [MD];
	logic [MD-1:0] dist_st [MD];
	logic [DW-1:0] det_st [MD];

	for (genvar k = 0; k < MD; k++) begin : g_stage
		localparam int B = MD - 1 - k;
		rti_pkg::ctl_t ctl_in;
		logic [RW-1:0] rem_in;
		logic [MD-1:0] dist_in;
		logic [DW-1:0] det_in;
		logic [RW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign ctl_in  = ctl_i;
			assign rem_in  = RW'(tsc_i);
			assign dist_in = '0;
			assign det_in  = det_i;
		end else begin : g_next
			assign ctl_in  = ctl_st[k-1];
			assign rem_in  = rem_st[k-1];
			assign dist_in = dist_st[k-1];
			assign det_in  = det_st[k-1];
		end

		assign trial = RW'(det_in) << B;
		assign take  = (trial <= rem_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_st[k] <= '0;
			end else begin
				ctl_st[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_st[k]  <= take ? rem_in - trial : rem_in;
			dist_st[k] <= take ? (dist_in | (MD'(1) << B)) : dist_in;
			det_st[k]  <= det_in;
		end
	end

	assign ctl_o  = ctl_st[MD-1];
	assign dist_o = dist_st[MD-1];

endmodule

/* rtl/core/ray_triangle_intersect.sv */
// ----------------------------------------------------------------------------
// Ray-triangle intersection core
// An accepted start reaches the done strobe through the cross, dot and divider stages and the output register.
// Throughput: one triangle per cycle; busy stays low and results cannot stall.
// The depth is set by the 31-stage distance divider, one bit per stage.
// Reset clears the pipeline valid bits and loads the default ray.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] vert0_x,
	input  logic signed [COORD_BITS-1:0] vert0_y,
	input  logic signed [COORD_BITS-1:0] vert0_z,
	input  logic signed [COORD_BITS-1:0] vert1_x,
	input  logic signed [COORD_BITS-1:0] vert1_y,
	input  logic signed [COORD_BITS-1:0] vert1_z,
	input  logic signed [COORD_BITS-1:0] vert2_x,
	input  logic signed [COORD_BITS-1:0] vert2_y,
	input  logic signed [COORD_BITS-1:0] vert2_z,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [((COORD_BITS > rti_pkg::MAXD_BITS) ? COORD_BITS : rti_pkg::MAXD_BITS)-1:0]
	                                     cfg_data,
	output logic                         done,
	output logic                         hit,
	output logic [rti_pkg::MAXD_BITS-1:0] hit_distance,
	output logic [2:0]                   miss_reason
);

	localparam int EW = COORD_BITS + 1;
	localparam int XW = 2 * EW + 1;
	localparam int DW = 3 * EW + 3;
	localparam int MD = rti_pkg::MAXD_BITS;

	logic signed [COORD_BITS-1:0] org_q [3];
	logic signed [COORD_BITS-1:0] dir_q [3];
	logic [MD-1:0]                maxd_q;
	logic signed [COORD_BITS-1:0] v0 [3], v1 [3], v2 [3];

	logic                 x_valid;
	logic signed [EW-1:0] e1 [3], e2 [3], s [3];
	logic signed [XW-1:0] h [3], q [3];
	rti_pkg::ctl_t        d_ctl, f_ctl;
	logic [DW-1:0]        det;
	logic [DW+FRAC_BITS-1:0] tsc;
	logic [MD-1:0]        quot;
	rti_pkg::reason_t     reason_f;

	logic                 done_q, hit_q;
	logic [MD-1:0]        dist_q;
	rti_pkg::reason_t     reason_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	assign v0 = '{vert0_x, vert0_y, vert0_z};
	assign v1 = '{vert1_x, vert1_y, vert1_z};
	assign v2 = '{vert2_x, vert2_y, vert2_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= COORD_BITS'(1) << FRAC_BITS;
			maxd_q   <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (rti_pkg::reg_idx_t'(cfg_index))
				rti_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data[COORD_BITS-1:0];
				rti_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data[COORD_BITS-1:0];
				rti_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data[COORD_BITS-1:0];
				rti_pkg::REG_DIR_X:    dir_q[0] <= cfg_data[COORD_BITS-1:0];
				rti_pkg::REG_DIR_Y:    dir_q[1] <= cfg_data[COORD_BITS-1:0];
				rti_pkg::REG_DIR_Z:    dir_q[2] <= cfg_data[COORD_BITS-1:0];
				rti_pkg::REG_MAX_DIST: maxd_q   <= cfg_data[MD-1:0];
				default: ;
			endcase
		end
	end

	rti_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.v0       (v0),
		.v1       (v1),
		.v2       (v2),
		.org      (org_q),
		.dir      (dir_q),
		.valid_o  (x_valid),
		.e1_o     (e1),
		.e2_o     (e2),
		.s_o      (s),
		.h_o      (h),
		.q_o      (q)
	);

	rti_dot #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (x_valid),
		.e1       (e1),
		.e2       (e2),
		.s        (s),
		.h        (h),
		.q        (q),
		.dir      (dir_q),
		.ctl_o    (d_ctl),
		.det_o    (det),
		.tsc_o    (tsc)
	);

	rti_div #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (d_ctl),
		.det_i  (det),
		.tsc_i  (tsc),
		.ctl_o  (f_ctl),
		.dist_o (quot)
	);

	// A hit whose distance reaches the limit is rejected here, after division.
	always_comb begin
		if (f_ctl.reason == rti_pkg::REASON_HIT && quot >= maxd_q) begin
			reason_f = rti_pkg::REASON_T_OUT;
		end else begin
			reason_f = f_ctl.reason;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= f_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q    <= (reason_f == rti_pkg::REASON_HIT);
		dist_q   <= (reason_f == rti_pkg::REASON_HIT) ? quot : '0;
		reason_q <= reason_f;
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;
	assign miss_reason  = reason_q;

endmodule

/* rtl/core/rti_checker.sv */
// ----------------------------------------------------------------------------
// Intersection core port checker
// Checks result consistency and fixed latency on the core's ports.
// ----------------------------------------------------------------------------
module rti_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           hit,
	input logic [rti_pkg::MAXD_BITS-1:0]  hit_distance,
	input logic [2:0]                     miss_reason
);

	a_hit_code : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit == (miss_reason == rti_pkg::REASON_HIT)))
		else $error("hit flag disagrees with miss reason");

	a_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> hit_distance == '0)
		else $error("distance not zero on a miss");

	a_reason_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> miss_reason <= rti_pkg::REASON_T_OUT)
		else $error("miss reason out of range");

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(rti_pkg::LATENCY) done)
		else $error("result beat missing after accepted triangle");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, rti_pkg::LATENCY))
		else $error("result beat without an accepted triangle");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

/* tb/sv/tb_ray_triangle_intersect.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray-triangle intersection testbench
// Streams triangles against several ray settings and checks every hit flag,
// distance and miss reason against fixed expected results or an exact wide-integer model of the test.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;

	typedef logic signed [31:0] coord_t;
	typedef coord_t tri_t [9];
	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic                          hit;
		logic [rti_pkg::MAXD_BITS-1:0] hdist;
		rti_pkg::reason_t              reason;
	} isect_t;

	typedef struct {
		tri_t   verts;
		logic   known;
		isect_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	coord_t vin [9];
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done;
	logic hit;
	logic [rti_pkg::MAXD_BITS-1:0] hit_distance;
	logic [2:0] miss_reason;

	coord_t ray_reg [6];
	logic [rti_pkg::MAXD_BITS-1:0] max_dist_reg;
	isect_t pending_hits [$];
	row_t directed [$];
	int n_err = 0;
	int gap_pct = 0;

	initial for (int i = 0; i < 9; i++) vin[i] = '0;

	always #10 clk = ~clk;

	ray_triangle_intersect u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vert0_x(vin[0]), .vert0_y(vin[1]), .vert0_z(vin[2]),
		.vert1_x(vin[3]), .vert1_y(vin[4]), .vert1_z(vin[5]),
		.vert2_x(vin[6]), .vert2_y(vin[7]), .vert2_z(vin[8]),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .hit(hit), .hit_distance(hit_distance),
		.miss_reason(miss_reason)
	);

	function automatic void cross3(input wide_t a [3], input wide_t b [3], output wide_t r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic wide_t dot(input wide_t a [3], input wide_t b [3]);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	function automatic isect_t predict(input tri_t t);
		wide_t e1 [3], e2 [3], s [3], d [3], h [3], q [3];
		wide_t det, un, vn, tn, tsc, lim, quo;
		isect_t r;
		r.hit = 1'b0;
		r.hdist = '0;
		r.reason = rti_pkg::REASON_HIT;
		for (int i = 0; i < 3; i++) begin
			e1[i] = wide_t'(t[3 + i]) - wide_t'(t[i]);
			e2[i] = wide_t'(t[6 + i]) - wide_t'(t[i]);
			s[i] = wide_t'(ray_reg[i]) - wide_t'(t[i]);
			d[i] = wide_t'(ray_reg[3 + i]);
		end
		cross3(d, e2, h);
		det = dot(e1, h);
		if (det == 0) begin
			r.reason = rti_pkg::REASON_PARALLEL;
			return r;
		end
		un = dot(s, h);
		cross3(s, e1, q);
		vn = dot(d, q);
		tn = dot(e2, q);
		if (det < 0) begin
			det = -det;
			un = -un;
			vn = -vn;
			tn = -tn;
		end
		tsc = tn <<< 16;
		lim = $signed({161'd0, max_dist_reg}) * det;
		if (un < 0 || un > det)
			r.reason = rti_pkg::REASON_U_OUT;
		else if (vn < 0 || un + vn > det)
			r.reason = rti_pkg::REASON_V_OUT;
		else if (tn <= 0 || tsc >= lim)
			r.reason = rti_pkg::REASON_T_OUT;
		else begin
			quo = tsc / det;
			r.hit = 1'b1;
			r.hdist = quo[rti_pkg::MAXD_BITS-1:0];
		end
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < rti_pkg::REG_MAX_DIST)
			ray_reg[idx] = val;
		else if (idx == rti_pkg::REG_MAX_DIST)
			max_dist_reg = val[rti_pkg::MAXD_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		wait (pending_hits.size() == 0);
		repeat (rti_pkg::LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_tri(input tri_t t, input logic known, input isect_t want);
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		for (int i = 0; i < 9; i++) vin[i] <= t[i];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_hits.push_back(known ? want : predict(t));
	endtask

	task automatic add_row(input tri_t t, input logic known, input logic h,
			input logic [rti_pkg::MAXD_BITS-1:0] dd, input rti_pkg::reason_t rs);
		row_t r;
		r.verts = t;
		r.known = known;
		r.res.hit = h;
		r.res.hdist = dd;
		r.res.reason = rs;
		directed.push_back(r);
	endtask

	function automatic coord_t rnd_coord(input int span_bits);
		coord_t c;
		c = $urandom;
		if (span_bits < 32)
			c = $signed(c) >>> (32 - span_bits);
		return c;
	endfunction

	always @(posedge clk) begin
		isect_t w;
		if (done) begin
			if (pending_hits.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result beat: hit=%0d dist=%0d reason=%0d",
						hit, hit_distance, miss_reason);
			end else begin
				w = pending_hits.pop_front();
				if (hit !== w.hit || hit_distance !== w.hdist || miss_reason !== w.reason) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp hit=%0d dist=%0d reason=%0d, got hit=%0d dist=%0d reason=%0d",
							w.hit, w.hdist, w.reason, hit, hit_distance, miss_reason);
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		localparam coord_t ONE = 32'sh0001_0000;
		tri_t t;
		isect_t nil;
		coord_t cv;
		nil = '{hit: 1'b0, hdist: '0, reason: rti_pkg::REASON_HIT};
		for (int i = 0; i < 6; i++) ray_reg[i] = '0;
		ray_reg[5] = ONE;
		max_dist_reg = '1;

		t = '{-ONE, -ONE, 5 * ONE, 4 * ONE, -ONE, 5 * ONE, -ONE, 4 * ONE, 5 * ONE};
		add_row(t, 1'b1, 1'b1, 31'd327680, rti_pkg::REASON_HIT);
		t = '{-ONE, -ONE, -5 * ONE, 4 * ONE, -ONE, -5 * ONE, -ONE, 4 * ONE, -5 * ONE};
		add_row(t, 1'b1, 1'b0, '0, rti_pkg::REASON_T_OUT);
		t = '{0, 0, 0, 0, ONE, 0, 0, 0, ONE};
		add_row(t, 1'b1, 1'b0, '0, rti_pkg::REASON_PARALLEL);
		t = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		add_row(t, 1'b1, 1'b0, '0, rti_pkg::REASON_PARALLEL);
		for (int i = 0; i < 9; i++) t[i] = 32'sh8000_0000;
		add_row(t, 1'b1, 1'b0, '0, rti_pkg::REASON_PARALLEL);
		for (int i = 0; i < 9; i++) t[i] = 32'sh7FFF_FFFF;
		add_row(t, 1'b1, 1'b0, '0, rti_pkg::REASON_PARALLEL);
		// Vertices and edges on the ray itself exercise the edge rules.
		t = '{0, 0, 3 * ONE, ONE, 0, 3 * ONE, 0, ONE, 3 * ONE};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{-ONE, 0, 3 * ONE, 0, 0, 3 * ONE, -ONE, ONE, 3 * ONE};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{-ONE, -ONE, 2 * ONE, ONE, ONE, 2 * ONE, -ONE, ONE, 2 * ONE};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{ONE, ONE, 4 * ONE, 3 * ONE, ONE, 4 * ONE, ONE, 3 * ONE, 4 * ONE};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{-ONE, ONE, 4 * ONE, ONE, ONE, 4 * ONE, -ONE, 3 * ONE, 4 * ONE};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{-ONE, -ONE, 0, 4 * ONE, -ONE, 0, -ONE, 4 * ONE, 0};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{32'sh8000_0000, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
			32'sh8000_0000, 32'sh7FFF_FFFF, 2};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);
		t = '{-1, -1, 1, 1, -1, 1, -1, 1, 1};
		add_row(t, 1'b0, 1'b0, '0, rti_pkg::REASON_HIT);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[k])
			send_tri(directed[k].verts, directed[k].known, directed[k].res);
		@(negedge clk);
		start <= 1'b0;
		drain();

		for (int p = 0; p < 6; p++) begin
			gap_pct = (p < 2) ? 38 : (p < 4) ? 77 : 0;
			for (int r = 0; r < 6; r++) begin
				case (p)
					0: cv = (r == 5) ? ONE : 0;
					3: cv = (r % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
					5: cv = (r >= 3) ? -rnd_coord(18) : rnd_coord(20);
					default: cv = rnd_coord(20);
				endcase
				write_reg(r[2:0], cv);
			end
			case (p)
				2: write_reg(rti_pkg::REG_MAX_DIST, 32'd0);
				3: write_reg(rti_pkg::REG_MAX_DIST, 32'hFFFF_FFFF);
				5: write_reg(rti_pkg::REG_MAX_DIST, 32'd1 << 18);
				default: write_reg(rti_pkg::REG_MAX_DIST, $urandom);
			endcase
			write_reg(3'd7, $urandom);
			for (int k = 0; k < 100; k++) begin
				for (int i = 0; i < 9; i++)
					t[i] = ($urandom_range(99) < 80) ? rnd_coord(21) : rnd_coord(32);
				if (k == 50) begin
					@(negedge clk);
					start <= 1'b0;
					wait (pending_hits.size() == 0);
				end
				send_tri(t, 1'b0, nil);
			end
			@(negedge clk);
			start <= 1'b0;
			drain();
		end

		if (n_err == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
rtl/core/rti_pkg.sv
rtl/core/rti_cross.sv
rtl/core/rti_dot.sv
rtl/core/rti_div.sv
rtl/core/ray_triangle_intersect.sv
rtl/core/rti_checker.sv
tb/sv/tb_ray_triangle_intersect.sv
